>>> hw/rtl/llbm_pkg.sv
// shared types, constants and level table for the luminance level best match block
package llbm_pkg;

   localparam int LEVEL_COUNT = 16;
   localparam int TREE_LEVELS = $clog2(LEVEL_COUNT);
   localparam int TREE_WIDTH  = 1 << TREE_LEVELS;

   localparam int COLOR_W = 8;
   localparam int PROD_W  = 16;
   localparam int SHIFT   = 7;
   localparam int SQ_W    = 16;
   localparam int DIST_W  = 18;
   localparam int INDEX_W = 4;

   localparam logic [DIST_W-1:0] MAX_DISTANCE = DIST_W'(195075);

   // offsets -128 .. 123 plus 128, masked to 8 bits
   localparam logic [COLOR_W-1:0] LEVEL_TABLE [16] = '{
      8'd0,   8'd44,  8'd76,  8'd96,  8'd108, 8'd116, 8'd120, 8'd124,
      8'd128, 8'd133, 8'd139, 8'd145, 8'd157, 8'd175, 8'd204, 8'd251
   };

   typedef struct packed {
      logic [COLOR_W-1:0] base_red;
      logic [COLOR_W-1:0] base_green;
      logic [COLOR_W-1:0] base_blue;
      logic [COLOR_W-1:0] source_red;
      logic [COLOR_W-1:0] source_green;
      logic [COLOR_W-1:0] source_blue;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_W-1:0] best_index;
      logic [DIST_W-1:0]  best_distance;
   } rsp_payload_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [SQ_W-1:0] red;
      logic [SQ_W-1:0] green;
      logic [SQ_W-1:0] blue;
   } sq_type;

   typedef struct packed {
      logic               ok;
      logic [INDEX_W-1:0] index;
      logic [DIST_W-1:0]  distance;
   } cand_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } stage_ctrl_type;

   function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                              input logic [COLOR_W-1:0] b);
      logic [COLOR_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

endpackage

>>> hw/rtl/llbm_scale.sv
// first stage: base colour scaled by every luminance level, with range flags
module llbm_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  llbm_pkg::stage_ctrl_type      ctrl,
   input  llbm_pkg::req_payload_type     req,
   output logic                          valid_ff,
   output llbm_pkg::rgb_type             scaled_ff [llbm_pkg::LEVEL_COUNT],
   output logic [llbm_pkg::LEVEL_COUNT-1:0] ok_ff,
   output llbm_pkg::rgb_type             source_ff
);
   import llbm_pkg::*;

   rgb_type                scaled_in [LEVEL_COUNT];
   logic [LEVEL_COUNT-1:0] ok_in;
   rgb_type                source_in;

   always_comb begin
      logic [PROD_W-1:0] pr;
      logic [PROD_W-1:0] pg;
      logic [PROD_W-1:0] pb;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
         pr = PROD_W'(req.base_red)   * PROD_W'(LEVEL_TABLE[i]);
         pg = PROD_W'(req.base_green) * PROD_W'(LEVEL_TABLE[i]);
         pb = PROD_W'(req.base_blue)  * PROD_W'(LEVEL_TABLE[i]);
         scaled_in[i].red   = pr[SHIFT +: COLOR_W];
         scaled_in[i].green = pg[SHIFT +: COLOR_W];
         scaled_in[i].blue  = pb[SHIFT +: COLOR_W];
         // the bit above the 8-bit result marks an overflow past 255
         ok_in[i] = !pr[PROD_W-1] && !pg[PROD_W-1] && !pb[PROD_W-1];
      end
      source_in.red   = req.source_red;
      source_in.green = req.source_green;
      source_in.blue  = req.source_blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         scaled_ff <= scaled_in;
         ok_ff     <= ok_in;
         source_ff <= source_in;
      end
   end

endmodule

>>> hw/rtl/llbm_dist.sv
// squared channel differences, then the per-level distance sum
module llbm_dist (
   input  logic                          clock,
   input  logic                          reset,
   input  llbm_pkg::stage_ctrl_type      ctrl,
   input  llbm_pkg::rgb_type             scaled [llbm_pkg::LEVEL_COUNT],
   input  logic [llbm_pkg::LEVEL_COUNT-1:0] ok,
   input  llbm_pkg::rgb_type             source,
   output logic                          valid_ff,
   output llbm_pkg::cand_type            cand_ff [llbm_pkg::LEVEL_COUNT]
);
   import llbm_pkg::*;

   sq_type                 sq_in [LEVEL_COUNT];
   sq_type                 sq_ff [LEVEL_COUNT];
   logic [LEVEL_COUNT-1:0] ok_sq_ff;
   logic                   sq_valid_ff;
   cand_type               cand_in [LEVEL_COUNT];

   always_comb begin
      for (int i = 0; i < LEVEL_COUNT; i++) begin
         sq_in[i].red   = sq_diff(scaled[i].red,   source.red);
         sq_in[i].green = sq_diff(scaled[i].green, source.green);
         sq_in[i].blue  = sq_diff(scaled[i].blue,  source.blue);
      end
   end

   always_comb begin
      for (int i = 0; i < LEVEL_COUNT; i++) begin
         cand_in[i].ok       = ok_sq_ff[i];
         cand_in[i].index    = INDEX_W'(i);
         cand_in[i].distance = DIST_W'(sq_ff[i].red) + DIST_W'(sq_ff[i].green)
                             + DIST_W'(sq_ff[i].blue);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else if (ctrl.advance) begin
         sq_valid_ff <= ctrl.valid;
         valid_ff    <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         sq_ff    <= sq_in;
         ok_sq_ff <= ok;
         cand_ff  <= cand_in;
      end
   end

endmodule

>>> hw/rtl/llbm_min_tree.sv
// registered compare tree picking the in-range level with least distance
module llbm_min_tree (
   input  logic                     clock,
   input  logic                     reset,
   input  llbm_pkg::stage_ctrl_type ctrl,
   input  llbm_pkg::cand_type       cand [llbm_pkg::LEVEL_COUNT],
   output logic                     valid_out,
   output llbm_pkg::cand_type       best
);
   import llbm_pkg::*;

   cand_type leaf [TREE_WIDTH];
   cand_type node_ff [TREE_WIDTH-1];
   logic     valid_ff [TREE_LEVELS];

   function automatic cand_type pick(input cand_type lo, input cand_type hi);
      // lower index wins ties
      if (hi.ok && (!lo.ok || hi.distance < lo.distance)) begin
         return hi;
      end
      return lo;
   endfunction

   always_comb begin
      for (int i = 0; i < TREE_WIDTH; i++) begin
         if (i < LEVEL_COUNT) begin
            leaf[i] = cand[i];
         end else begin
            leaf[i] = '0;
         end
      end
   end

   // heap layout: node k has children 2k+1 and 2k+2, leaves follow the nodes
   for (genvar k = 0; k < TREE_WIDTH - 1; k++) begin : g_node
      if (2 * k + 1 >= TREE_WIDTH - 1) begin : g_from_leaf
         always_ff @(posedge clock) begin
            if (ctrl.advance) begin
               node_ff[k] <= pick(leaf[2 * k + 1 - (TREE_WIDTH - 1)],
                                  leaf[2 * k + 2 - (TREE_WIDTH - 1)]);
            end
         end
      end else begin : g_from_node
         always_ff @(posedge clock) begin
            if (ctrl.advance) begin
               node_ff[k] <= pick(node_ff[2 * k + 1], node_ff[2 * k + 2]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < TREE_LEVELS; l++) begin
            valid_ff[l] <= 1'b0;
         end
      end else if (ctrl.advance) begin
         valid_ff[0] <= ctrl.valid;
         for (int l = 1; l < TREE_LEVELS; l++) begin
            valid_ff[l] <= valid_ff[l-1];
         end
      end
   end

   assign valid_out = valid_ff[TREE_LEVELS-1];
   assign best      = node_ff[0];

endmodule

>>> hw/rtl/luminance_level_best_match.sv
// top level: input skid stage, scale, distance and compare-tree pipeline
//
// Use: each beat on req_ carries a base colour and a source colour (8-bit RGB).
// The block scales the base colour by sixteen fixed luminance levels, drops
// levels where any channel passes 255, and returns on rsp_ the index of the
// level nearest to the source colour (lowest index on ties) and its squared
// distance. Level 0 is always in range, so every beat gets one result.
// Pipeline: 7 register stages (1 scale, 2 distance, 4 compare-tree).
// Throughput: one beat per cycle; the whole pipeline moves together on one
// advance signal, so a beat can enter every cycle while rsp_ready stays high.
// Stall: while rsp_valid is high and rsp_ready low, every stage holds. A beat
// arriving then is parked in a one-entry skid register and req_ready drops
// the next cycle; req_ready comes from a register, not from rsp_ready.
// Reset: synchronous, active high; clears all valid bits and the skid entry.
module luminance_level_best_match (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  llbm_pkg::req_payload_type   req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output llbm_pkg::rsp_payload_type   rsp_payload
);
   import llbm_pkg::*;

   logic            skid_valid_ff;
   logic            skid_valid_in;
   req_payload_type skid_ff;
   logic            advance;
   logic            accept;
   stage_ctrl_type  head_ctrl;
   stage_ctrl_type  dist_ctrl;
   stage_ctrl_type  tree_ctrl;
   req_payload_type head_req;

   logic                   scale_valid;
   rgb_type                scaled [LEVEL_COUNT];
   logic [LEVEL_COUNT-1:0] scaled_ok;
   rgb_type                source;
   logic                   dist_valid;
   cand_type               cand [LEVEL_COUNT];
   cand_type               best;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      head_ctrl.advance = advance;
      head_ctrl.valid   = skid_valid_ff || accept;
      dist_ctrl.advance = advance;
      dist_ctrl.valid   = scale_valid;
      tree_ctrl.advance = advance;
      tree_ctrl.valid   = dist_valid;
      head_req          = skid_valid_ff ? skid_ff : req_payload;
      skid_valid_in     = skid_valid_ff;
      if (skid_valid_ff && advance) begin
         skid_valid_in = 1'b0;
      end else if (accept && !advance) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !advance) begin
         skid_ff <= req_payload;
      end
   end

   llbm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (head_ctrl),
      .req       (head_req),
      .valid_ff  (scale_valid),
      .scaled_ff (scaled),
      .ok_ff     (scaled_ok),
      .source_ff (source)
   );

   llbm_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (dist_ctrl),
      .scaled   (scaled),
      .ok       (scaled_ok),
      .source   (source),
      .valid_ff (dist_valid),
      .cand_ff  (cand)
   );

   llbm_min_tree u_min_tree (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (tree_ctrl),
      .cand      (cand),
      .valid_out (rsp_valid),
      .best      (best)
   );

   assign rsp_payload.best_index    = best.index;
   assign rsp_payload.best_distance = best.distance;

`ifndef SYNTHESIS
   // a beat taken during a stall must land in the skid entry
   assert property (@(posedge clock) disable iff (reset)
      (accept && !advance) |=> skid_valid_ff)
      else $error("stalled beat not parked in skid entry");

   // a parked beat leaves the skid entry as soon as the pipeline moves
   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && advance) |=> !skid_valid_ff)
      else $error("skid entry not drained on advance");

   // level 0 is always in range, so the winner is always a valid level
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (best.ok && rsp_payload.best_distance <= MAX_DISTANCE))
      else $error("result without an in-range level");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_payload.best_index) < LEVEL_COUNT))
      else $error("result index beyond level count");
`endif

endmodule

>>> sim/tb_top.sv
// testbench for luminance_level_best_match: directed table, random pixel pairs, self-checking
`timescale 1ns / 100ps

module tb_top;
   import llbm_pkg::*;

   localparam int unsigned LUMA_LEVELS [16] = '{
      0, 44, 76, 96, 108, 116, 120, 124, 128, 133, 139, 145, 157, 175, 204, 251
   };
   localparam int RANDOM_PIXELS = 1800;
   localparam int DIRECTED_ROWS = 25;

   typedef struct packed {
      req_payload_type pixel;
      logic            known;
      rsp_payload_type match;
   } directed_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   rsp_payload_type pending_matches [$];
   int              mismatch_count = 0;
   int              results_checked = 0;
   int              rsp_hold = 0;
   bit              quiet_phase = 1'b0;

   // gray base 128 maps each level onto itself, so each source gray picks one index
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{8'd128, 8'd128, 8'd128, 8'd0,   8'd0,   8'd0  }, 1'b1, '{4'd0,  18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd44,  8'd44,  8'd44 }, 1'b1, '{4'd1,  18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd76,  8'd76,  8'd76 }, 1'b1, '{4'd2,  18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd96,  8'd96,  8'd96 }, 1'b1, '{4'd3,  18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd108, 8'd108, 8'd108}, 1'b1, '{4'd4,  18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd116, 8'd116, 8'd116}, 1'b1, '{4'd5,  18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd120, 8'd120, 8'd120}, 1'b1, '{4'd6,  18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd124, 8'd124, 8'd124}, 1'b1, '{4'd7,  18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128}, 1'b1, '{4'd8,  18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd133, 8'd133, 8'd133}, 1'b1, '{4'd9,  18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd139, 8'd139, 8'd139}, 1'b1, '{4'd10, 18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd145, 8'd145, 8'd145}, 1'b1, '{4'd11, 18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd157, 8'd157, 8'd157}, 1'b1, '{4'd12, 18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd175, 8'd175, 8'd175}, 1'b1, '{4'd13, 18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd204, 8'd204, 8'd204}, 1'b1, '{4'd14, 18'd0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd251, 8'd251, 8'd251}, 1'b1, '{4'd15, 18'd0}},
      '{'{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  }, 1'b1, '{4'd0,  18'd0}},
      // black base: every level ties at full distance, lowest index wins
      '{'{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255}, 1'b1, '{4'd0,  18'd195075}},
      '{'{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0  }, 1'b1, '{4'd0,  18'd0}},
      // white base: levels above 128 overflow and drop out
      '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, '{4'd8,  18'd0}},
      // base 1: levels 8..15 all give 1, first of them is kept
      '{'{8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1  }, 1'b1, '{4'd8,  18'd0}},
      '{'{8'd200, 8'd200, 8'd200, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
      '{'{8'd255, 8'd0,   8'd128, 8'd10,  8'd200, 8'd77 }, 1'b0, '0},
      '{'{8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255}, 1'b0, '0},
      '{'{8'd170, 8'd85,  8'd15,  8'd240, 8'd120, 8'd20 }, 1'b0, '0}
   };

   luminance_level_best_match u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   // search the in-range levels for the one closest to the source color
   function automatic rsp_payload_type nearest_level(input req_payload_type px);
      rsp_payload_type best;
      bit              have;
      int              count;
      int unsigned     cr, cg, cb;
      int              dr, dg, db;
      int unsigned     level_dist;
      best = '0;
      have = 1'b0;
      count = (LEVEL_COUNT > 16) ? 16 : (LEVEL_COUNT < 1) ? 1 : LEVEL_COUNT;
      for (int i = 0; i < count; i++) begin
         cr = (int'(px.base_red)   * LUMA_LEVELS[i]) >> 7;
         cg = (int'(px.base_green) * LUMA_LEVELS[i]) >> 7;
         cb = (int'(px.base_blue)  * LUMA_LEVELS[i]) >> 7;
         if (cr <= 255 && cg <= 255 && cb <= 255) begin
            dr = int'(cr) - int'(px.source_red);
            dg = int'(cg) - int'(px.source_green);
            db = int'(cb) - int'(px.source_blue);
            level_dist = dr * dr + dg * dg + db * db;
            if (!have || level_dist < best.best_distance) begin
               have = 1'b1;
               best.best_index = i[INDEX_W-1:0];
               best.best_distance = level_dist[DIST_W-1:0];
            end
         end
      end
      return best;
   endfunction

   function automatic int idle_draw();
      return quiet_phase ? 0 : $urandom_range(0, 14);
   endfunction

   // source channel close to a scaled base channel, so varied levels win
   function automatic logic [7:0] near_channel(input logic [7:0] base, input int unsigned lv);
      int scaled;
      scaled = (int'(base) * lv) >> 7;
      if (scaled > 255)
         return 8'($urandom_range(0, 255));
      scaled = scaled + $urandom_range(0, 6) - 3;
      return (scaled < 0) ? 8'd0 : (scaled > 255) ? 8'd255 : 8'(scaled);
   endfunction

   function automatic req_payload_type random_pixel();
      req_payload_type px;
      int unsigned     pick;
      int unsigned     lv;
      pick = $urandom_range(0, 99);
      px = req_payload_type'(48'({$urandom, $urandom}));
      lv = LUMA_LEVELS[$urandom_range(0, 15)];
      if (pick < 45) begin
         px.source_red   = near_channel(px.base_red, lv);
         px.source_green = near_channel(px.base_green, lv);
         px.source_blue  = near_channel(px.base_blue, lv);
      end else if (pick < 60) begin
         // bright bases push the upper levels out of range
         px.base_red   = 8'($urandom_range(160, 255));
         px.base_green = 8'($urandom_range(160, 255));
         px.base_blue  = 8'($urandom_range(160, 255));
      end else if (pick < 70) begin
         // dim bases give many equal distances
         px.base_red   = 8'($urandom_range(0, 3));
         px.base_green = 8'($urandom_range(0, 3));
         px.base_blue  = 8'($urandom_range(0, 3));
      end
      return px;
   endfunction

   // call at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_pixel(input req_payload_type px, input rsp_payload_type match);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= px;
      do @(posedge clock); while (!req_ready);
      pending_matches.push_back(match);
      @(negedge clock);
   endtask

   // result side: random stall after each beat
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_matches.size() == 0) begin
            $error("result with nothing expected: best_index %0d best_distance %0d",
                   rsp_payload.best_index, rsp_payload.best_distance);
            mismatch_count++;
         end else begin
            want = pending_matches.pop_front();
            if (rsp_payload.best_index !== want.best_index) begin
               $error("best_index: expected %0d, got %0d",
                      want.best_index, rsp_payload.best_index);
               mismatch_count++;
            end
            if (rsp_payload.best_distance !== want.best_distance) begin
               $error("best_distance: expected %0d, got %0d",
                      want.best_distance, rsp_payload.best_distance);
               mismatch_count++;
            end
         end
         results_checked++;
         rsp_hold = idle_draw();
      end
   end

   initial begin
      req_payload_type px;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r])
         send_pixel(directed_rows[r].pixel,
                    directed_rows[r].known ? directed_rows[r].match
                                           : nearest_level(directed_rows[r].pixel));

      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         if (n % 50 == 0)
            quiet_phase = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_PIXELS / 2) begin
            // let the pipeline drain completely before carrying on
            req_valid <= 1'b0;
            wait (pending_matches.size() == 0);
            @(negedge clock);
         end
         px = random_pixel();
         send_pixel(px, nearest_level(px));
      end
      req_valid <= 1'b0;

      wait (pending_matches.size() == 0);
      repeat (20) @(posedge clock);
      if (pending_matches.size() != 0) begin
         $error("%0d results never arrived", pending_matches.size());
         mismatch_count++;
      end
      $display("run covered %0d table rows and %0d random pixel pairs, %0d results compared",
               DIRECTED_ROWS, RANDOM_PIXELS, results_checked);
      $display("sender gaps and result stalls of 0 to 14 cycles, with quiet stretches");
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("timeout waiting for results");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
